FILE: rtl/assert_macros.svh
// Assertion helpers for the range table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IMR_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IMR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/imr_pkg.sv
// ----------------------------------------------------------------------------
// imr_pkg
// Types and codes for the interval map range table.
// ----------------------------------------------------------------------------
package imr_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] key_begin;
    logic signed [KEY_W-1:0] key_end;
    logic [VAL_W-1:0]        new_value;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCATE,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_BEGIN,
    PH_END,
    PH_DONE
  } phase_t;

endpackage

FILE: rtl/imr_cell.sv
// ----------------------------------------------------------------------------
// imr_cell
// One boundary slot: takes its neighbour's entry or a loaded entry.
// ----------------------------------------------------------------------------
module imr_cell
  import imr_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  entry_t shift_in,
  input  logic   load_en,
  input  entry_t load_in,
  output entry_t entry
);

  entry_t entry_r;

  // load wins over shift
  always_ff @(posedge clk) begin
    if (load_en) begin
      entry_r <= load_in;
    end else if (shift_en) begin
      entry_r <= shift_in;
    end
  end

  assign entry = entry_r;

endmodule

FILE: rtl/interval_map_range_table.sv
// ----------------------------------------------------------------------------
// interval_map_range_table
// Sorted boundary table with interval assign and point lookup.
// ----------------------------------------------------------------------------
// The table is a row of DEPTH boundary cells, sorted by signed key, plus a
// scratch row of the same size. A lookup compares every cell with the key at
// once and picks the last boundary at or below it (the default register when
// there is none), with the result moved through the locate and done states
// into the output register. An assign first looks up the value at key_end,
// then rotates the table row once round (DEPTH steps) through cell 0; each
// head entry below key_begin or above key_end is passed to the scratch row,
// with the begin and end boundaries slotted in at their place, and any entry
// whose value equals the one before it is dropped. If the result fits, the
// scratch row is copied back into the table row; otherwise the table is left
// as it was and status reports full. An empty interval goes straight to the
// done state. One word is worked on at a time; the result sits in an output
// register, so the next word is taken while the last result is still stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interval_map_range_table
  import imr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_wdata
);

  localparam int SW = $clog2(DEPTH + 1);  // step and count width
  localparam int MW = $clog2(DEPTH + 2);  // scratch fill, may pass DEPTH

  // rows of cells
  entry_t tbl [DEPTH];
  entry_t res [DEPTH];

  logic [DEPTH-1:0] sel_v;
  logic [DEPTH-1:0] last_v;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  in_word_t          item_r, item_nxt;
  logic [SW-1:0]     count_r, count_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [MW-1:0]     m_r, m_nxt;
  logic [VAL_W-1:0]  default_r;
  logic [VAL_W-1:0]  end_val_r, end_val_nxt;
  logic [VAL_W-1:0]  prev_r, prev_nxt;
  logic [VAL_W-1:0]  res_val_r, res_val_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic signed [KEY_W-1:0] probe;
  logic [VAL_W-1:0]        hit_or;
  logic [VAL_W-1:0]        hit_val;

  logic   rot;
  logic   commit_we;
  logic   emit_go;
  logic   emit_keep;
  logic   emit_we;
  entry_t emit_e;
  logic   head_valid;
  logic   head_lt;
  logic   head_gt;
  logic   out_free;

  // lookup key for a lookup, end key for an assign
  assign probe = (item_r.operation == OP_LOOKUP) ? item_r.key_begin : item_r.key_end;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    imr_cell u_tbl (
      .clk      (clk),
      .shift_en (rot),
      .shift_in (tbl[(i + 1) % DEPTH]),
      .load_en  (commit_we),
      .load_in  (res[i]),
      .entry    (tbl[i])
    );

    imr_cell u_res (
      .clk      (clk),
      .shift_en (1'b0),
      .shift_in (res[i]),
      .load_en  (emit_we && (m_r == MW'(i))),
      .load_in  (emit_e),
      .entry    (res[i])
    );

    assign sel_v[i] = (SW'(i) < count_r) && ($signed(tbl[i].key) <= probe);
  end

  // last boundary at or below the probe; the row is sorted, so this is one-hot
  assign last_v = sel_v & ~{1'b0, sel_v[DEPTH-1:1]};

  always_comb begin
    hit_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_or = hit_or | ({VAL_W{last_v[i]}} & tbl[i].value);
    end
  end

  assign hit_val = (|sel_v) ? hit_or : default_r;

  // head of the rotating row
  assign head_valid = step_r < count_r;
  assign head_lt    = $signed(tbl[0].key) < item_r.key_begin;
  assign head_gt    = $signed(tbl[0].key) > item_r.key_end;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    m_nxt         = m_r;
    end_val_nxt   = end_val_r;
    prev_nxt      = prev_r;
    res_val_nxt   = res_val_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    rot           = 1'b0;
    commit_we     = 1'b0;
    emit_go       = 1'b0;
    emit_e        = tbl[0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_word;
          res_val_nxt = '0;
          stat_nxt    = STAT_DONE;
          if (in_word.operation == OP_ASSIGN && !(in_word.key_begin < in_word.key_end)) begin
            stat_nxt  = STAT_EMPTY;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LOCATE;
          end
        end
      end
      S_LOCATE: begin
        if (item_r.operation == OP_LOOKUP) begin
          res_val_nxt = hit_val;
          state_nxt   = S_DONE;
        end else begin
          end_val_nxt = hit_val;
          prev_nxt    = default_r;
          m_nxt       = '0;
          step_nxt    = '0;
          phase_nxt   = PH_BEGIN;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (phase_r != PH_DONE && (step_r == SW'(DEPTH) || !(head_valid && head_lt))) begin
          // slot the new boundaries in, one a cycle, while the row holds
          emit_go = 1'b1;
          if (phase_r == PH_BEGIN) begin
            emit_e.key   = item_r.key_begin;
            emit_e.value = item_r.new_value;
            phase_nxt    = PH_END;
          end else begin
            emit_e.key   = item_r.key_end;
            emit_e.value = end_val_r;
            phase_nxt    = PH_DONE;
          end
        end else if (step_r == SW'(DEPTH)) begin
          state_nxt = S_COMMIT;
        end else begin
          rot      = 1'b1;
          step_nxt = step_r + 1'b1;
          emit_go  = head_valid && (head_lt || head_gt);
        end
      end
      S_COMMIT: begin
        if (m_r > MW'(DEPTH)) begin
          stat_nxt = STAT_FULL;
        end else begin
          commit_we = 1'b1;
          count_nxt = SW'(m_r);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.read_value  = res_val_r;
          out_word_nxt.status      = stat_r;
          out_word_nxt.entry_count = COUNT_W'(count_r);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // drop entries that repeat the value before them
    emit_keep = emit_go && (emit_e.value != prev_r);
    emit_we   = emit_keep && (m_r < MW'(DEPTH));
    if (emit_keep) begin
      prev_nxt = emit_e.value;
      if (m_r <= MW'(DEPTH)) begin
        m_nxt = m_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_BEGIN;
      count_r     <= '0;
      step_r      <= '0;
      m_r         <= '0;
      default_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        default_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    end_val_r  <= end_val_nxt;
    prev_r     <= prev_nxt;
    res_val_r  <= res_val_nxt;
    stat_r     <= stat_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `IMR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= SW'(DEPTH))
  `IMR_ASSERT_NOW(a_rotation_done, clk, rst_n, state_r == S_COMMIT,
                  step_r == SW'(DEPTH) && phase_r == PH_DONE)
  `IMR_ASSERT_NEXT(a_commit_count, clk, rst_n,
                   state_r == S_COMMIT && m_r <= MW'(DEPTH), count_r == SW'($past(m_r)))

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the interval map range table against a behavioural table model:
// directed assigns and lookups, default changes, full-table rejects, random
// traffic with idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import imr_pkg::*;

  localparam int TBL_DEPTH   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_we;
  logic [VAL_W-1:0] cfg_wdata;

  interval_map_range_table #(.DEPTH(TBL_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow table kept in step with the block.
  logic signed [KEY_W-1:0] shadow_keys [TBL_DEPTH];
  logic [VAL_W-1:0]        shadow_vals [TBL_DEPTH];
  int                      shadow_used;
  logic [VAL_W-1:0]        shadow_default;

  out_word_t expected_words[$];
  int        error_count;
  int        cycle_count;
  bit        idle_enable;   // random bursts of idling on both sides
  bit        hold_request;  // ask the receiver for a long hold-off
  int        hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit: generous against slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL interval_map_range_table");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] value_at(logic signed [KEY_W-1:0] key);
    logic [VAL_W-1:0] v;
    v = shadow_default;
    for (int i = 0; i < shadow_used; i++) begin
      if (shadow_keys[i] <= key) v = shadow_vals[i];
      else break;
    end
    return v;
  endfunction

  // Interval assign on the shadow table; returns the status code.
  function automatic logic [STAT_W-1:0] assign_interval(logic signed [KEY_W-1:0] kb,
                                                        logic signed [KEY_W-1:0] ke,
                                                        logic [VAL_W-1:0] nv);
    logic signed [KEY_W-1:0] tk [TBL_DEPTH+2];
    logic [VAL_W-1:0]        tv [TBL_DEPTH+2];
    logic [VAL_W-1:0]        end_val, prev;
    int n, m;
    n = 0;
    m = 0;
    if (!(kb < ke)) return STAT_EMPTY;
    end_val = value_at(ke);
    for (int i = 0; i < shadow_used; i++)
      if (shadow_keys[i] < kb) begin
        tk[n] = shadow_keys[i]; tv[n] = shadow_vals[i]; n++;
      end
    tk[n] = kb; tv[n] = nv; n++;
    tk[n] = ke; tv[n] = end_val; n++;
    for (int i = 0; i < shadow_used; i++)
      if (shadow_keys[i] > ke && n < TBL_DEPTH + 2) begin
        tk[n] = shadow_keys[i]; tv[n] = shadow_vals[i]; n++;
      end
    // drop boundaries that repeat the value before them
    prev = shadow_default;
    for (int i = 0; i < n; i++)
      if (tv[i] != prev) begin
        tk[m] = tk[i]; tv[m] = tv[i]; prev = tv[i]; m++;
      end
    if (m > TBL_DEPTH) return STAT_FULL;
    for (int i = 0; i < m; i++) begin
      shadow_keys[i] = tk[i];
      shadow_vals[i] = tv[i];
    end
    shadow_used = m;
    return STAT_DONE;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.operation == OP_LOOKUP) r.read_value = value_at(w.key_begin);
    else r.status = assign_interval(w.key_begin, w.key_end, w.new_value);
    r.entry_count = COUNT_W'(shadow_used);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  // Result checker, compares each accepted word with the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_word.read_value !== want.read_value)
          report_mismatch("read_value", out_word.read_value, want.read_value);
        if (out_word.status !== want.status)
          report_mismatch("status", out_word.status, want.status);
        if (out_word.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_word.entry_count, want.entry_count);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 300) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_request = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Sends one word; the expectation is computed at acceptance.
  task automatic send_word(logic op, logic signed [KEY_W-1:0] kb,
                           logic signed [KEY_W-1:0] ke, logic [VAL_W-1:0] nv);
    in_word_t w;
    w.operation = op;
    w.key_begin = kb;
    w.key_end   = ke;
    w.new_value = nv;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(predict_word(w));
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Quiet the input and wait for every expected word plus the block's latency.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_default(logic [VAL_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_default = v;
  endtask

  function automatic logic signed [KEY_W-1:0] rand_key(bit narrow);
    if (narrow) return KEY_W'($signed($urandom_range(0, 60)) - 30);
    return $urandom;
  endfunction

  task automatic test_directed;
    send_word(OP_LOOKUP, 0, 0, 0);                       // empty table lookup
    send_word(OP_ASSIGN, 5, 5, 8'hAA);                   // empty interval
    send_word(OP_ASSIGN, 9, 3, 8'hAA);                   // reversed interval
    send_word(OP_ASSIGN, 32'sh8000_0000, 32'sh7fff_ffff, 8'hFF);
    send_word(OP_LOOKUP, 32'sh8000_0000, 0, 0);
    send_word(OP_LOOKUP, 32'sh7fff_ffff, 0, 0);
    send_word(OP_ASSIGN, -10, 10, 8'h00);
    send_word(OP_ASSIGN, 0, 4, 8'h11);
    send_word(OP_ASSIGN, 2, 3, 8'h11);                   // merges away
    send_word(OP_LOOKUP, -10, 0, 0);
    send_word(OP_LOOKUP, 3, 0, 0);
    send_word(OP_LOOKUP, 10, 32'sh7fff_ffff, 8'hFF);
    send_word(OP_ASSIGN, 32'sh8000_0000, 32'sh7fff_ffff, 8'h00);
  endtask

  // Fill the table with alternating values until it rejects.
  task automatic test_table_full;
    for (int i = 0; i < 12; i++)
      send_word(OP_ASSIGN, i * 4, i * 4 + 2, 8'(i + 1));
    send_word(OP_ASSIGN, 100, 101, 8'h55);
    send_word(OP_LOOKUP, 9, 0, 0);
  endtask

  // Default changed under a live table, then an assign tidies it.
  task automatic test_default_change;
    write_default(8'd1);
    send_word(OP_LOOKUP, -1000, 0, 0);
    send_word(OP_LOOKUP, 1, 0, 0);
    send_word(OP_ASSIGN, 200, 300, 8'd7);
    write_default(8'hFF);
    send_word(OP_ASSIGN, 32'sh8000_0000, 32'sh7fff_ffff, 8'hFF);
  endtask

  task automatic test_random(int count);
    bit narrow;
    logic signed [KEY_W-1:0] a, b;
    for (int i = 0; i < count; i++) begin
      narrow = ($urandom_range(0, 9) != 0);
      a = rand_key(narrow);
      b = rand_key(narrow);
      if ($urandom_range(0, 9) != 0 && a > b) begin
        a = a ^ b; b = a ^ b; a = a ^ b;
      end
      send_word(1'($urandom_range(0, 1)), a, b,
                narrow ? 8'($urandom_range(0, 4)) : 8'($urandom));
    end
  endtask

  // Offer words during a long receiver hold-off so the block backs up.
  task automatic test_backpressure;
    hold_request = 1'b1;
    test_random(20);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    error_count  = 0;
    cycle_count  = 0;
    idle_enable  = 1'b1;
    hold_request = 1'b0;
    shadow_used  = 0;
    shadow_default = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_default_change();
    write_default(8'd0);
    test_random(500);
    test_backpressure();
    write_default(8'd2);
    test_random(500);
    write_default(8'hFF);
    test_random(300);
    write_default(8'd0);
    idle_enable = 1'b0;   // final stretch without idling
    test_random(350);
    drain();

    if (error_count == 0) $display("PASS interval_map_range_table");
    else $display("FAIL interval_map_range_table");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/imr_pkg.sv
rtl/imr_cell.sv
rtl/interval_map_range_table.sv
verif/testbench.sv
